[rtl/core/cmn_pkg.sv]
// ----------------------------------------------------------------------------
// Crop, mirror and normalize: shared definitions
// Field widths, register indexes, channel payloads and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cmn_pkg;

  localparam int MAX_DIM_DEF  = 4096;
  localparam int MAX_CHANNELS = 3;
  localparam int CH_W         = 2;

  localparam int CFG_DIM_W = 13;
  localparam int POS_W     = 17;
  localparam int POS_FRAC  = 16;
  localparam int CROP_W    = 2 * POS_W;
  localparam int FMT_W     = 2;
  localparam int TABLE_W   = 48;
  localparam int ENTRY_W   = 16;
  localparam int IDX_W     = 3;

  localparam int SAMPLE_W    = 8;
  localparam int DIFF_W      = ENTRY_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int ROUND_SHIFT = 4;
  localparam int VALUE_W     = 32;
  localparam int OFF_W       = 26;

  localparam int FMT_COLOR_BIT = 0;
  localparam int FMT_NCHW_BIT  = 1;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << POS_FRAC);

  typedef enum logic [IDX_W-1:0] {
    REG_IN_HEIGHT,
    REG_IN_WIDTH,
    REG_OUT_HEIGHT,
    REG_OUT_WIDTH,
    REG_CROP_POSITION,
    REG_FORMAT_MODE,
    REG_MEAN_TABLE,
    REG_SCALE_TABLE
  } reg_index_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                mirror;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [OFF_W-1:0]          dest_offset;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [TABLE_W-1:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] in_height;
    logic [CFG_DIM_W-1:0] in_width;
    logic [CFG_DIM_W-1:0] out_height;
    logic [CFG_DIM_W-1:0] out_width;
    logic [CROP_W-1:0]    crop_position;
    logic [FMT_W-1:0]     format_mode;
    logic [TABLE_W-1:0]   mean_table;
    logic [TABLE_W-1:0]   scale_table;
  } cfg_regs_t;

  typedef struct packed {
    logic in_ready;
    logic load_input;
    logic crop_y;
    logic crop_x;
    logic check;
    logic mul1;
    logic mul2;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first;
    logic in_window;
    logic out_free;
  } dp_status_t;

  // Channel indexes above two share the last table entry.
  function automatic logic [ENTRY_W-1:0] entry_sel(input logic [TABLE_W-1:0] tbl,
                                                   input logic [CH_W-1:0] c);
    logic [ENTRY_W-1:0] e;
    case (c)
      2'd0:    e = tbl[ENTRY_W-1:0];
      2'd1:    e = tbl[2*ENTRY_W-1:ENTRY_W];
      default: e = tbl[3*ENTRY_W-1:2*ENTRY_W];
    endcase
    return e;
  endfunction

endpackage

[rtl/core/cmn_stream_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per transfer; a transfer happens at a rising edge with
// valid and ready both high.
// ----------------------------------------------------------------------------
interface cmn_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/crop_mirror_normalize_top.sv]
// ----------------------------------------------------------------------------
// Crop, mirror and normalize
// Crops an 8-bit HWC image stream, optionally mirrors it horizontally and
// normalizes each kept sample per channel to signed Q15.16 with its offset in
// the NCHW or NHWC output image.
// ----------------------------------------------------------------------------
// Usage: write the configuration through cfg while no image sample is in
// flight. Source samples arrive on samples in raster order, one per transfer;
// the mirror bit is taken with the first sample of each image. Each sample in
// the crop window gives one transfer on results; samples outside give none.
// Samples pass one at a time through the shared multiply sequence in the
// datapath: a sample outside the window ends after the window check, a
// sample inside goes on through the multiply steps and the output step,
// and on the first sample of an image the row and column crop steps come
// first, while one multiplier works out the row and column crop offsets.
// The output register holds a result until it is taken; the next sample is
// accepted meanwhile, and the sequencer waits in its output step only when a
// second result is ready before the first has been taken.
// Reset returns the configuration registers to their defaults (sizes one,
// the rest zero) and restarts the position counters at the top of an image.
// ----------------------------------------------------------------------------
module crop_mirror_normalize_top #(
  parameter int MAX_DIM = cmn_pkg::MAX_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cmn_stream_if.sink    samples,
  cmn_stream_if.source  results,
  cmn_stream_if.sink    cfg
);

  cmn_pkg::cfg_regs_t  regs;
  cmn_pkg::ctrl_cmd_t  cmd;
  cmn_pkg::dp_status_t status;

  cmn_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  cmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .status   (status),
    .cmd      (cmd)
  );

  assign samples.ready = cmd.in_ready;

  cmn_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .regs      (regs),
    .in_item   (samples.data),
    .out_ready (results.ready),
    .status    (status),
    .out_valid (results.valid),
    .out_item  (results.data)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("Sample accepted while the previous one was still in progress.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!results.valid || results.ready))
    else $error("Output register loaded over a result that was not taken.");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_input, cmd.crop_y, cmd.crop_x, cmd.check,
              cmd.mul1, cmd.mul2, cmd.load_out}))
    else $error("More than one sequencer step commanded in a cycle.");
`endif

endmodule

[rtl/core/cmn_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Decodes writes on the configuration channel and holds the register file.
// ----------------------------------------------------------------------------
module cmn_regs (
  input  logic                clk,
  input  logic                rst,
  cmn_stream_if.sink          cfg,
  output cmn_pkg::cfg_regs_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.in_height     <= cmn_pkg::CFG_DIM_W'(1);
      regs.in_width      <= cmn_pkg::CFG_DIM_W'(1);
      regs.out_height    <= cmn_pkg::CFG_DIM_W'(1);
      regs.out_width     <= cmn_pkg::CFG_DIM_W'(1);
      regs.crop_position <= '0;
      regs.format_mode   <= '0;
      regs.mean_table    <= '0;
      regs.scale_table   <= '0;
    end else if (cfg.valid) begin
      case (cmn_pkg::reg_index_t'(cfg.data.index))
        cmn_pkg::REG_IN_HEIGHT: begin
          regs.in_height <= cfg.data.value[cmn_pkg::CFG_DIM_W-1:0];
        end
        cmn_pkg::REG_IN_WIDTH: begin
          regs.in_width <= cfg.data.value[cmn_pkg::CFG_DIM_W-1:0];
        end
        cmn_pkg::REG_OUT_HEIGHT: begin
          regs.out_height <= cfg.data.value[cmn_pkg::CFG_DIM_W-1:0];
        end
        cmn_pkg::REG_OUT_WIDTH: begin
          regs.out_width <= cfg.data.value[cmn_pkg::CFG_DIM_W-1:0];
        end
        cmn_pkg::REG_CROP_POSITION: begin
          regs.crop_position <= cfg.data.value[cmn_pkg::CROP_W-1:0];
        end
        cmn_pkg::REG_FORMAT_MODE: begin
          regs.format_mode <= cfg.data.value[cmn_pkg::FMT_W-1:0];
        end
        cmn_pkg::REG_MEAN_TABLE: begin
          regs.mean_table <= cfg.data.value;
        end
        cmn_pkg::REG_SCALE_TABLE: begin
          regs.scale_table <= cfg.data.value;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/cmn_ctrl.sv]
// ----------------------------------------------------------------------------
// Sequencing controller
// Steps one sample at a time through crop offset setup, window check,
// multiplication, rounding and output load.
// ----------------------------------------------------------------------------
module cmn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  cmn_pkg::dp_status_t status,
  output cmn_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CROP_Y,
    S_CROP_X,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_OUTPUT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_input = 1'b1;
          state_next     = status.first ? S_CROP_Y : S_CHECK;
        end
      end
      S_CROP_Y: begin
        cmd.crop_y = 1'b1;
        state_next = S_CROP_X;
      end
      S_CROP_X: begin
        cmd.crop_x = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.in_window ? S_MUL1 : S_IDLE;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/cmn_dp.sv]
// ----------------------------------------------------------------------------
// Datapath
// Source position counters, crop offsets, window test, normalization
// arithmetic, destination offset and the output register.
// ----------------------------------------------------------------------------
module cmn_dp #(
  parameter int MAX_DIM = cmn_pkg::MAX_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmn_pkg::ctrl_cmd_t  cmd,
  input  cmn_pkg::cfg_regs_t  regs,
  input  cmn_pkg::in_item_t   in_item,
  input  logic                out_ready,
  output cmn_pkg::dp_status_t status,
  output logic                out_valid,
  output cmn_pkg::out_item_t  out_item
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int SZ_W  = DIM_W + 1;
  localparam int SUM_W = (2 * SZ_W + 2 > cmn_pkg::OFF_W) ? 2 * SZ_W + 2 : cmn_pkg::OFF_W;
  localparam int CP_W  = SZ_W + cmn_pkg::POS_W;
  localparam int CH_W  = cmn_pkg::CH_W;

  localparam logic [SZ_W-1:0] DIM_MAX = SZ_W'(MAX_DIM);

  function automatic logic [SZ_W-1:0] clamp_dim(input logic [cmn_pkg::CFG_DIM_W-1:0] v,
                                                input logic [SZ_W-1:0] hi);
    logic [SZ_W-1:0] r;
    if (v == '0) begin
      r = SZ_W'(1);
    end else if (32'(v) > 32'(hi)) begin
      r = hi;
    end else begin
      r = SZ_W'(v);
    end
    return r;
  endfunction

  logic [SZ_W-1:0] ih, iw, oh, ow;
  logic [CH_W-1:0] nch;
  logic            nchw;

  logic [DIM_W-1:0] row_count, column_count;
  logic [CH_W-1:0]  channel_count;
  logic             mirror_latched;
  logic [DIM_W-1:0] row_offset, column_offset;
  logic [cmn_pkg::SAMPLE_W-1:0] sample;

  logic [SZ_W-1:0]            crop_span;
  logic [cmn_pkg::POS_W-1:0]  crop_pos_raw, crop_pos;
  logic [CP_W-1:0]            crop_prod;

  logic [DIM_W-1:0] row_rel, col_rel;
  logic             row_in, col_in, in_window;
  logic [SZ_W-1:0]  w_pos;
  logic             last_hit;
  logic [cmn_pkg::ENTRY_W-1:0] mean_entry, scale_entry;
  logic signed [cmn_pkg::DIFF_W-1:0] diff_next;

  logic [CH_W:0]  ch_inc;
  logic [SZ_W-1:0] col_inc, row_inc;

  logic [DIM_W-1:0] h;
  logic [SZ_W-1:0]  w;
  logic [CH_W-1:0]  c;
  logic             last;
  logic signed [cmn_pkg::DIFF_W-1:0] diff;
  logic [cmn_pkg::ENTRY_W-1:0] scale;
  logic [SUM_W-1:0] plane;

  logic signed [cmn_pkg::PROD_W-1:0] prod;
  logic [SUM_W-1:0] hw;

  logic [cmn_pkg::PROD_W-1:0] mag, q;
  logic signed [cmn_pkg::VALUE_W-1:0] value_next, value;
  logic [SUM_W-1:0] pix, cplane, off_sum;

  assign ih   = clamp_dim(regs.in_height, DIM_MAX);
  assign iw   = clamp_dim(regs.in_width, DIM_MAX);
  assign oh   = clamp_dim(regs.out_height, ih);
  assign ow   = clamp_dim(regs.out_width, iw);
  assign nch  = regs.format_mode[cmn_pkg::FMT_COLOR_BIT] ? CH_W'(cmn_pkg::MAX_CHANNELS)
                                                         : CH_W'(1);
  assign nchw = regs.format_mode[cmn_pkg::FMT_NCHW_BIT];

  // One multiplier serves both crop offsets, row first, then column.
  always_comb begin
    if (cmd.crop_x) begin
      crop_span    = iw - ow;
      crop_pos_raw = regs.crop_position[cmn_pkg::CROP_W-1:cmn_pkg::POS_W];
    end else begin
      crop_span    = ih - oh;
      crop_pos_raw = regs.crop_position[cmn_pkg::POS_W-1:0];
    end
    crop_pos  = (crop_pos_raw > cmn_pkg::POS_ONE) ? cmn_pkg::POS_ONE : crop_pos_raw;
    crop_prod = CP_W'(crop_span) * CP_W'(crop_pos);
  end

  always_comb begin
    row_rel     = row_count - row_offset;
    col_rel     = column_count - column_offset;
    row_in      = (row_count >= row_offset) && ({1'b0, row_rel} < oh);
    col_in      = (column_count >= column_offset) && ({1'b0, col_rel} < ow);
    in_window   = row_in && col_in && (channel_count < nch);
    w_pos       = mirror_latched ? (ow - SZ_W'(1) - {1'b0, col_rel}) : {1'b0, col_rel};
    last_hit    = ({1'b0, col_rel} == ow - SZ_W'(1)) && ({1'b0, row_rel} == oh - SZ_W'(1))
                  && (channel_count == nch - CH_W'(1));
    mean_entry  = cmn_pkg::entry_sel(regs.mean_table, channel_count);
    scale_entry = cmn_pkg::entry_sel(regs.scale_table, channel_count);
    diff_next   = $signed({1'b0, sample, 8'h00}) - $signed({1'b0, mean_entry});
    ch_inc      = {1'b0, channel_count} + (CH_W+1)'(1);
    col_inc     = {1'b0, column_count} + SZ_W'(1);
    row_inc     = {1'b0, row_count} + SZ_W'(1);
  end

  assign status.first     = (row_count == '0) && (column_count == '0) && (channel_count == '0);
  assign status.in_window = in_window;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= '0;
      column_count   <= '0;
      channel_count  <= '0;
      mirror_latched <= 1'b0;
      row_offset     <= '0;
      column_offset  <= '0;
    end else begin
      if (cmd.load_input && status.first) begin
        mirror_latched <= in_item.mirror;
      end
      if (cmd.crop_y) begin
        row_offset <= crop_prod[cmn_pkg::POS_FRAC +: DIM_W];
      end
      if (cmd.crop_x) begin
        column_offset <= crop_prod[cmn_pkg::POS_FRAC +: DIM_W];
      end
      if (cmd.check) begin
        if (ch_inc >= {1'b0, nch}) begin
          channel_count <= '0;
          if (col_inc >= iw) begin
            column_count <= '0;
            if (row_inc >= ih) begin
              row_count <= '0;
            end else begin
              row_count <= row_inc[DIM_W-1:0];
            end
          end else begin
            column_count <= col_inc[DIM_W-1:0];
          end
        end else begin
          channel_count <= ch_inc[CH_W-1:0];
        end
      end
    end
  end

  // The magnitude stays below 2^28 after rounding, so the result never saturates.
  always_comb begin
    mag        = prod[cmn_pkg::PROD_W-1] ? cmn_pkg::PROD_W'(-prod) : cmn_pkg::PROD_W'(prod);
    q          = (mag + cmn_pkg::PROD_W'(8)) >> cmn_pkg::ROUND_SHIFT;
    value_next = $signed(q[cmn_pkg::VALUE_W-1:0]);
    if (prod[cmn_pkg::PROD_W-1]) begin
      value_next = -value_next;
    end
    off_sum = nchw ? (cplane + pix) : (pix * SUM_W'(nch) + SUM_W'(c));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      sample <= in_item.sample;
    end
    if (cmd.check) begin
      h     <= row_rel;
      w     <= w_pos;
      c     <= channel_count;
      last  <= last_hit;
      diff  <= diff_next;
      scale <= scale_entry;
      plane <= SUM_W'(oh) * SUM_W'(ow);
    end
    if (cmd.mul1) begin
      prod <= diff * $signed({1'b0, scale});
      hw   <= SUM_W'(h) * SUM_W'(ow);
    end
    if (cmd.mul2) begin
      value  <= value_next;
      pix    <= hw + SUM_W'(w);
      cplane <= SUM_W'(c) * plane;
    end
    if (cmd.load_out) begin
      out_item.value       <= value;
      out_item.dest_offset <= off_sum[cmn_pkg::OFF_W-1:0];
      out_item.last        <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[bench/crop_mirror_normalize_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Crop, mirror and normalize: testbench
// Streams source images through the block under many register settings,
// predicts every kept sample's normalized value, output offset and end flag,
// and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module crop_mirror_normalize_top_tb;
  import cmn_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int ITEM_TARGET   = 1850;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 200;

  typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_t;

  logic clk;
  logic rst;

  cmn_stream_if #(.payload_t(in_item_t))   samples_ch ();
  cmn_stream_if #(.payload_t(out_item_t))  results_ch ();
  cmn_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

  crop_mirror_normalize_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  logic [CFG_DIM_W-1:0] in_h_reg, in_w_reg, out_h_reg, out_w_reg;
  logic [CROP_W-1:0]    crop_reg;
  logic [FMT_W-1:0]     fmt_reg;
  logic [TABLE_W-1:0]   mean_reg, scale_reg;
  logic [11:0]          row_pos, col_pos, row_off, col_off;
  logic [1:0]           chan_pos;
  logic                 mirror_held;

  in_item_t    pending_samples[$];
  out_item_t   expected_results[$];
  logic        input_taken = 1'b0;
  int unsigned items_queued = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mode_left = 0;
  int unsigned stall_left = 0;
  rx_pattern_t rx_pattern = RX_STEADY;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void frame_geometry(output int unsigned ih, iw, oh, ow, nch);
    ih  = clamp_size(in_h_reg, MAX_DIM_DEF);
    iw  = clamp_size(in_w_reg, MAX_DIM_DEF);
    oh  = clamp_size(out_h_reg, ih);
    ow  = clamp_size(out_w_reg, iw);
    nch = fmt_reg[FMT_COLOR_BIT] ? MAX_CHANNELS : 1;
  endfunction

  function automatic void advance_raster(inout logic [11:0] row, inout logic [11:0] col,
                                         inout logic [1:0] ch, input int unsigned ih,
                                         input int unsigned iw, input int unsigned nch);
    int unsigned ch_next;
    ch_next = ch + 1;
    if (ch_next >= nch) begin
      ch = '0;
      if (col + 1 >= iw) begin
        col = '0;
        if (row + 1 >= ih) row = '0;
        else row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    end else begin
      ch = ch_next[1:0];
    end
  endfunction

  function automatic logic [11:0] crop_origin(input int unsigned in_sz,
                                              input int unsigned out_sz,
                                              input logic [POS_W-1:0] pos);
    longint unsigned p, span;
    p = (pos > POS_ONE) ? POS_ONE : pos;
    span = in_sz - out_sz;
    return 12'((span * p) >> POS_FRAC);
  endfunction

  task automatic predict_sample(input in_item_t it);
    int unsigned ih, iw, oh, ow, nch, h, wr, w, c, t, mean_v, scale_v, off;
    longint      prod, mag, q, v;
    out_item_t   exp_r;
    frame_geometry(ih, iw, oh, ow, nch);
    if (row_pos == 0 && col_pos == 0 && chan_pos == 0) begin
      mirror_held = it.mirror;
      row_off = crop_origin(ih, oh, crop_reg[POS_W-1:0]);
      col_off = crop_origin(iw, ow, crop_reg[CROP_W-1:POS_W]);
    end
    if (row_pos >= row_off && row_pos - row_off < oh &&
        col_pos >= col_off && col_pos - col_off < ow && chan_pos < nch) begin
      h  = row_pos - row_off;
      wr = col_pos - col_off;
      w  = mirror_held ? ow - 1 - wr : wr;
      c  = chan_pos;
      t  = (c > 2) ? 2 : c;
      mean_v  = mean_reg[ENTRY_W*t +: ENTRY_W];
      scale_v = scale_reg[ENTRY_W*t +: ENTRY_W];
      prod = (longint'(it.sample) * 256 - longint'(mean_v)) * longint'(scale_v);
      mag  = (prod < 0) ? -prod : prod;
      q    = (mag + 8) >> ROUND_SHIFT;
      v    = (prod < 0) ? -q : q;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      if (fmt_reg[FMT_NCHW_BIT]) off = c * oh * ow + h * ow + w;
      else off = (h * ow + w) * nch + c;
      exp_r.value       = v[VALUE_W-1:0];
      exp_r.dest_offset = off[OFF_W-1:0];
      exp_r.last        = (wr == ow - 1 && h == oh - 1 && c == nch - 1);
      expected_results = {expected_results, exp_r};
    end
    advance_raster(row_pos, col_pos, chan_pos, ih, iw, nch);
  endtask

  task automatic apply_register(input cfg_write_t wr_item);
    case (reg_index_t'(wr_item.index))
      REG_IN_HEIGHT:     in_h_reg  = wr_item.value[CFG_DIM_W-1:0];
      REG_IN_WIDTH:      in_w_reg  = wr_item.value[CFG_DIM_W-1:0];
      REG_OUT_HEIGHT:    out_h_reg = wr_item.value[CFG_DIM_W-1:0];
      REG_OUT_WIDTH:     out_w_reg = wr_item.value[CFG_DIM_W-1:0];
      REG_CROP_POSITION: crop_reg  = wr_item.value[CROP_W-1:0];
      REG_FORMAT_MODE:   fmt_reg   = wr_item.value[FMT_W-1:0];
      REG_MEAN_TABLE:    mean_reg  = wr_item.value;
      REG_SCALE_TABLE:   scale_reg = wr_item.value;
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string field, input longint want, input longint got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: result with nothing expected: value %0d offset %0d last %0b",
                 $time, got.value, got.dest_offset, got.last);
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.value !== want.value) note_mismatch("value", want.value, got.value);
    if (got.dest_offset !== want.dest_offset)
      note_mismatch("dest_offset", want.dest_offset, got.dest_offset);
    if (got.last !== want.last) note_mismatch("last", want.last, got.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      input_taken = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.data);
      if (results_ch.valid && results_ch.ready) check_result(results_ch.data);
      input_taken = samples_ch.valid && samples_ch.ready;
      if (input_taken) predict_sample(samples_ch.data);
    end
  end

  always @(negedge clk) begin
    in_item_t nxt_item;
    logic     nxt_valid;
    nxt_item  = samples_ch.data;
    nxt_valid = samples_ch.valid;
    if (rst) begin
      nxt_item  = '0;
      nxt_valid = 1'b0;
    end else if (!samples_ch.valid || input_taken) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_samples.size() > 0) begin
        nxt_item  = pending_samples.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    samples_ch.valid <= nxt_valid;
    samples_ch.data  <= nxt_item;
  end

  always @(negedge clk) begin
    logic nxt_ready;
    if (mode_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    case (rx_pattern)
      RX_STEADY: nxt_ready = 1'b1;
      RX_COIN:   nxt_ready = 1'($urandom);
      RX_SPARSE: nxt_ready = ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          nxt_ready = 1'b0;
        end else begin
          nxt_ready = 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(4, 20);
        end
      end
    endcase
    results_ch.ready <= nxt_ready;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [TABLE_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  task automatic load_settings(input logic [CFG_DIM_W-1:0] ih, iw, oh, ow,
                               input logic [CROP_W-1:0] crop, input logic [FMT_W-1:0] fmt,
                               input logic [TABLE_W-1:0] mean, scale);
    write_reg(REG_IN_HEIGHT, TABLE_W'(ih));
    write_reg(REG_IN_WIDTH, TABLE_W'(iw));
    write_reg(REG_OUT_HEIGHT, TABLE_W'(oh));
    write_reg(REG_OUT_WIDTH, TABLE_W'(ow));
    write_reg(REG_CROP_POSITION, TABLE_W'(crop));
    write_reg(REG_FORMAT_MODE, TABLE_W'(fmt));
    write_reg(REG_MEAN_TABLE, mean);
    write_reg(REG_SCALE_TABLE, scale);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || samples_ch.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void push_sample(input logic [SAMPLE_W-1:0] s, input logic m);
    in_item_t it;
    it.sample = s;
    it.mirror = m;
    pending_samples = {pending_samples, it};
    items_queued++;
  endfunction

  function automatic void push_random(input int unsigned n);
    repeat (n) push_sample(SAMPLE_W'($urandom), 1'($urandom));
  endfunction

  function automatic int unsigned samples_to_frame_start();
    int unsigned ih, iw, oh, ow, nch, n;
    logic [11:0] r, cc;
    logic [1:0]  ch;
    frame_geometry(ih, iw, oh, ow, nch);
    r  = row_pos;
    cc = col_pos;
    ch = chan_pos;
    n  = 0;
    while (r != 0 || cc != 0 || ch != 0) begin
      advance_raster(r, cc, ch, ih, iw, nch);
      n++;
    end
    return n;
  endfunction

  function automatic void queue_frames(input int unsigned frames, input bit ragged_end);
    int unsigned ih, iw, oh, ow, nch, frame_len;
    frame_geometry(ih, iw, oh, ow, nch);
    frame_len = ih * iw * nch;
    push_random(samples_to_frame_start() + frames * frame_len);
    if (ragged_end) push_random($urandom_range(1, frame_len));
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return POS_ONE;
      2: return POS_W'($urandom_range(32'h10001, 32'h1FFFF));
      default: return POS_W'($urandom_range(0, 32'h10000));
    endcase
  endfunction

  task automatic random_settings();
    logic [CFG_DIM_W-1:0] ih, iw, oh, ow;
    ih = CFG_DIM_W'($urandom_range(1, 8));
    iw = CFG_DIM_W'($urandom_range(1, 8));
    if ($urandom_range(0, 9) == 0) ih = CFG_DIM_W'($urandom_range(9, 16));
    if ($urandom_range(0, 19) == 0) iw = '0;
    oh = CFG_DIM_W'($urandom_range(0, ih + 1));
    ow = CFG_DIM_W'($urandom_range(0, iw + 1));
    load_settings(ih, iw, oh, ow, {pick_position(), pick_position()},
                  FMT_W'($urandom_range(0, 3)),
                  {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
  endtask

  initial begin
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    in_h_reg  = CFG_DIM_W'(1);
    in_w_reg  = CFG_DIM_W'(1);
    out_h_reg = CFG_DIM_W'(1);
    out_w_reg = CFG_DIM_W'(1);
    crop_reg  = '0;
    fmt_reg   = '0;
    mean_reg  = '0;
    scale_reg = '0;
    row_pos   = '0;
    col_pos   = '0;
    chan_pos  = '0;
    row_off   = '0;
    col_off   = '0;
    mirror_held = 1'b0;
    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: one-pixel gray image with zero tables.
    push_sample(8'h00, 1'b0);
    push_sample(8'hFF, 1'b1);
    wait_drained();

    // Largest image and window, mirrored, full-scale gain.
    load_settings(13'd4096, 13'd4096, 13'd4096, 13'd4096, '0, 2'b01, '0, '1);
    push_sample(8'hFF, 1'b1);
    push_sample(8'h00, 1'b0);
    push_sample(8'hFF, 1'b0);
    push_sample(8'h01, 1'b1);
    wait_drained();

    // Sizes of zero and above the maximum, crop positions above one, largest
    // means; the counters carry over from the unfinished image above.
    load_settings(13'd0, 13'd2, 13'h1FFF, 13'd0, {17'h1FFFF, 17'h1FFFF}, 2'b11,
                  '1, {3{16'h1000}});
    queue_frames(1, 1'b0);
    push_random(3);
    wait_drained();

    // Shrink below the current column so the counters must wrap.
    load_settings(13'd1, 13'd1, 13'd1, 13'd1, '0, 2'b00,
                  {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
    queue_frames(2, 1'b0);

    while (items_queued < ITEM_TARGET) begin
      wait_drained();
      random_settings();
      queue_frames($urandom_range(1, 3), $urandom_range(0, 4) == 0);
    end
    wait_drained();

    if (expected_results.size() != 0) error_count++;
    $display("Streamed %0d source samples under %0d register settings.",
             items_queued, settings_used);
    $display("Checked %0d normalized results, %0d errors.", results_checked, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
